// ===== sv/oehp_pkg.sv =====
// Package with the item types, codes and name tables of the object header parser.
`timescale 1ns / 1ps
`default_nettype none

package oehp_pkg;

  localparam int unsigned SizeW = 64;
  localparam int unsigned LenW  = 8;
  localparam int unsigned NumTypes = 3;
  localparam int unsigned NamePos = 8;

  // Result status codes.
  localparam logic [3:0] ST_RUNNING       = 4'd0;
  localparam logic [3:0] ST_OK            = 4'd1;
  localparam logic [3:0] ST_HDR_TOO_LONG  = 4'd2;
  localparam logic [3:0] ST_HDR_MALFORMED = 4'd3;
  localparam logic [3:0] ST_BAD_TYPE      = 4'd4;
  localparam logic [3:0] ST_BAD_SIZE      = 4'd5;
  localparam logic [3:0] ST_TOO_LARGE     = 4'd6;
  localparam logic [3:0] ST_TRAILING      = 4'd7;
  localparam logic [3:0] ST_TRUNC_HDR     = 4'd8;
  localparam logic [3:0] ST_TRUNC_PAYLOAD = 4'd9;

  // Object type codes.
  localparam logic [1:0] TYPE_BLOB   = 2'd0;
  localparam logic [1:0] TYPE_TREE   = 2'd1;
  localparam logic [1:0] TYPE_COMMIT = 2'd2;

  // Register select: bit 3 of paddr picks the register (byte addresses 0 and 8).
  localparam int unsigned RegSelBit   = 3;
  localparam logic        REG_CAPTURE = 1'b0;
  localparam logic        REG_MAX_PAY = 1'b1;
  localparam logic [SizeW-1:0] MaxPayloadReset = 64'd268435456;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // Type names, one row per type, position 0 in the lowest byte.
  localparam logic [NumTypes-1:0][NamePos-1:0][7:0] NAME_TEXT = '{
    '{8'h00, 8'h00, 8'h74, 8'h69, 8'h6d, 8'h6d, 8'h6f, 8'h63},  // commit
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h65, 8'h65, 8'h72, 8'h74},  // tree
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h62, 8'h6f, 8'h6c, 8'h62}   // blob
  };
  localparam logic [NumTypes-1:0][LenW-1:0] NAME_LEN = '{8'd6, 8'd4, 8'd4};

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_object;
  } in_item_t;

  typedef struct packed {
    logic             payload_valid;
    logic [7:0]       payload_byte;
    logic             header_done;
    logic [1:0]       object_type;
    logic [SizeW-1:0] declared_size;
    logic [3:0]       status;
  } res_item_t;

  // A classified byte as it travels from the front to the back.
  typedef struct packed {
    logic [7:0]                       data;
    logic                             last;
    logic                             is_nul;
    logic                             is_space;
    logic                             is_digit;
    logic [3:0]                       digit;
    logic [NumTypes-1:0][NamePos-1:0] name_hit;
  } cls_t;

endpackage

`default_nettype wire

// ===== sv/oehp_fifo.sv =====
// Two-entry queue used between the parser stages and on the result side.
`timescale 1ns / 1ps
`default_nettype none

module oehp_fifo #(
  parameter int unsigned Width = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output logic [Width-1:0]      data_o
);

  logic [Width-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    unique case ({do_push, do_pop})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/oehp_front.sv =====
// Front end: classifies each incoming byte and queues it for the parser.
`timescale 1ns / 1ps
`default_nettype none

module oehp_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  output logic                   full_o,
  input  wire oehp_pkg::in_item_t in_item_i,
  output logic                   cls_valid_o,
  input  wire logic              cls_pop_i,
  output oehp_pkg::cls_t         cls_o
);
  import oehp_pkg::*;

  cls_t                cls;
  logic                cls_empty;
  logic [$bits(cls_t)-1:0] cls_raw;

  always_comb begin
    cls.data     = in_item_i.in_byte;
    cls.last     = in_item_i.end_of_object;
    cls.is_nul   = (in_item_i.in_byte == 8'h00);
    cls.is_space = (in_item_i.in_byte == CHAR_SPACE);
    cls.is_digit = (in_item_i.in_byte >= CHAR_ZERO) && (in_item_i.in_byte <= CHAR_NINE);
    cls.digit    = 4'(in_item_i.in_byte - CHAR_ZERO);
    for (int k = 0; k < NumTypes; k++) begin
      for (int p = 0; p < NamePos; p++) begin
        // A hit only counts at a position that lies inside the name.
        cls.name_hit[k][p] = (LenW'(p) < NAME_LEN[k]) &&
                             (NAME_TEXT[k][p] == in_item_i.in_byte);
      end
    end
  end

  oehp_fifo #(
    .Width($bits(cls_t))
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .data_i (cls),
    .full_o (full_o),
    .pop_i  (cls_pop_i),
    .empty_o(cls_empty),
    .data_o (cls_raw)
  );

  assign cls_valid_o = !cls_empty;
  assign cls_o       = cls_t'(cls_raw);

endmodule

`default_nettype wire

// ===== sv/oehp_back.sv =====
// Back end: header/payload FSM, one classified byte per cycle unless stalled.
`timescale 1ns / 1ps
`default_nettype none

module oehp_back #(
  parameter int unsigned HEADER_MAX = 128
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cls_valid_i,
  input  wire oehp_pkg::cls_t             cls_i,
  output logic                            cls_pop_o,
  input  wire logic                       res_full_i,
  output logic                            res_push_o,
  output oehp_pkg::res_item_t             res_o,
  input  wire logic                       capture_enable_i,
  input  wire logic [oehp_pkg::SizeW-1:0] max_payload_i
);
  import oehp_pkg::*;

  typedef enum logic [1:0] {
    PH_TYPE = 2'd0,
    PH_SIZE = 2'd1,
    PH_BODY = 2'd2,
    PH_STOP = 2'd3
  } phase_e;

  localparam logic [LenW-1:0] HdrMax = LenW'(HEADER_MAX);

  phase_e             phase_q, phase_d;
  logic [LenW-1:0]    hdr_len_q, hdr_len_d;
  logic [NumTypes-1:0] match_q, match_d;
  logic [LenW-1:0]    type_len_q, type_len_d;
  logic               size_seen_q, size_seen_d;
  logic               size_bad_q, size_bad_d;
  logic [SizeW-1:0]   acc_q, acc_d;
  logic [SizeW-1:0]   count_q, count_d;
  logic [3:0]         err_q, err_d;
  logic               hdr_ok_q, hdr_ok_d;

  logic               fire;
  logic [SizeW+3:0]   acc_next;
  logic [NumTypes-1:0] len_ok;
  logic [NumTypes-1:0] match_closed;
  logic               valid, done;
  logic [1:0]         type_code;
  logic [3:0]         status;

  assign fire       = cls_valid_i && !res_full_i;
  assign cls_pop_o  = fire;
  assign res_push_o = fire;

  // Size digit step: acc*10 + d in a word wide enough to see an overflow.
  assign acc_next = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + (SizeW+4)'(cls_i.digit);

  always_comb begin
    for (int k = 0; k < NumTypes; k++) begin
      len_ok[k] = (type_len_q == NAME_LEN[k]);
    end
    match_closed = match_q & len_ok;
  end

  always_comb begin
    phase_d     = phase_q;
    hdr_len_d   = hdr_len_q;
    match_d     = match_q;
    type_len_d  = type_len_q;
    size_seen_d = size_seen_q;
    size_bad_d  = size_bad_q;
    acc_d       = acc_q;
    count_d     = count_q;
    err_d       = err_q;
    hdr_ok_d    = hdr_ok_q;
    valid       = 1'b0;
    done        = 1'b0;

    unique case (phase_q)
      PH_TYPE, PH_SIZE: begin
        if (cls_i.is_nul) begin
          // Header is judged in the order the fields appear.
          if (phase_q != PH_SIZE || type_len_q == '0 || !size_seen_q) begin
            err_d   = ST_HDR_MALFORMED;
            phase_d = PH_STOP;
          end else begin
            match_d = match_closed;
            if (match_closed == '0) begin
              err_d   = ST_BAD_TYPE;
              phase_d = PH_STOP;
            end else if (size_bad_q) begin
              err_d   = ST_BAD_SIZE;
              phase_d = PH_STOP;
            end else if (capture_enable_i && (acc_q > max_payload_i)) begin
              err_d   = ST_TOO_LARGE;
              phase_d = PH_STOP;
            end else begin
              phase_d  = PH_BODY;
              hdr_ok_d = 1'b1;
              done     = 1'b1;
            end
          end
        end else if (hdr_len_q >= HdrMax) begin
          err_d   = ST_HDR_TOO_LONG;
          phase_d = PH_STOP;
        end else begin
          hdr_len_d = hdr_len_q + LenW'(1);
          if (phase_q == PH_TYPE) begin
            if (cls_i.is_space) begin
              phase_d = PH_SIZE;
            end else begin
              for (int k = 0; k < NumTypes; k++) begin
                if (!cls_i.name_hit[k][type_len_q[2:0]] || (type_len_q >= LenW'(NamePos))) begin
                  match_d[k] = 1'b0;
                end
              end
              if (type_len_q != '1) begin
                type_len_d = type_len_q + LenW'(1);
              end
            end
          end else begin
            size_seen_d = 1'b1;
            if (!size_bad_q) begin
              if (!cls_i.is_digit || (acc_next[SizeW+3:SizeW] != '0)) begin
                size_bad_d = 1'b1;
              end else begin
                acc_d = acc_next[SizeW-1:0];
              end
            end
          end
        end
      end
      PH_BODY: begin
        if (count_q >= acc_q) begin
          err_d   = ST_TRAILING;
          phase_d = PH_STOP;
        end else begin
          count_d = count_q + SizeW'(1);
          valid   = 1'b1;
        end
      end
      PH_STOP: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    priority if (match_d[0]) begin
      type_code = TYPE_BLOB;
    end else if (match_d[1]) begin
      type_code = TYPE_TREE;
    end else begin
      type_code = TYPE_COMMIT;
    end

    status = err_d;
    if (cls_i.last && err_d == ST_RUNNING) begin
      priority if (phase_d == PH_TYPE || phase_d == PH_SIZE) begin
        status = ST_TRUNC_HDR;
      end else if (count_d != acc_d) begin
        status = ST_TRUNC_PAYLOAD;
      end else begin
        status = ST_OK;
      end
    end

    res_o.payload_valid = valid;
    res_o.payload_byte  = valid ? cls_i.data : 8'h00;
    res_o.header_done   = done;
    res_o.object_type   = hdr_ok_d ? type_code : TYPE_BLOB;
    res_o.declared_size = hdr_ok_d ? acc_d : '0;
    res_o.status        = status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_TYPE;
      hdr_len_q   <= '0;
      match_q     <= '1;
      type_len_q  <= '0;
      size_seen_q <= 1'b0;
      size_bad_q  <= 1'b0;
      acc_q       <= '0;
      count_q     <= '0;
      err_q       <= ST_RUNNING;
      hdr_ok_q    <= 1'b0;
    end else if (fire) begin
      if (cls_i.last) begin
        // The final byte closes the object and readies the next one.
        phase_q     <= PH_TYPE;
        hdr_len_q   <= '0;
        match_q     <= '1;
        type_len_q  <= '0;
        size_seen_q <= 1'b0;
        size_bad_q  <= 1'b0;
        acc_q       <= '0;
        count_q     <= '0;
        err_q       <= ST_RUNNING;
        hdr_ok_q    <= 1'b0;
      end else begin
        phase_q     <= phase_d;
        hdr_len_q   <= hdr_len_d;
        match_q     <= match_d;
        type_len_q  <= type_len_d;
        size_seen_q <= size_seen_d;
        size_bad_q  <= size_bad_d;
        acc_q       <= acc_d;
        count_q     <= count_d;
        err_q       <= err_d;
        hdr_ok_q    <= hdr_ok_d;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/object_envelope_header_parser.sv =====
// Top level of the object envelope header parser with its register port.
`timescale 1ns / 1ps
`default_nettype none

// The parser takes the inflated bytes of a stored object, one item per clock,
// in the form "type SP decimal-size NUL payload", and returns one result item
// for every input item, in order. Each cycle a byte is taken when push_i is
// high and full_o is low; results wait in a two-entry queue and leave when
// pop_i is high and empty_o is low. With pop_i held high the block sustains
// one item per cycle. A taken item is written into the classification queue;
// the parsing state machine, whose longest path is the 64-bit size
// multiply-add by ten, pops it from there and writes its result into the
// result queue, from which it can be popped.
// Both sides stall independently through the queue between the front end
// and the state machine. The status field shows the sticky error or zero on
// ordinary bytes and the final verdict on the byte marked end_of_object,
// after which all parsing state clears for the next object. The register
// capture_enable sits at byte address 0 and max_payload at byte address 8;
// only paddr bit 3 is decoded. Registers must be written only while no item
// is in flight.
module object_envelope_header_parser #(
  parameter int unsigned HEADER_MAX = 128
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push_i,
  output logic                              full_o,
  input  wire oehp_pkg::in_item_t           in_item_i,
  output logic                              empty_o,
  input  wire logic                         pop_i,
  output oehp_pkg::res_item_t               out_item_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [3:0]                   paddr,
  input  wire logic [63:0]                  pwdata,
  output logic [63:0]                       prdata,
  output logic                              pready
);
  import oehp_pkg::*;

  logic             capture_enable_q;
  logic [SizeW-1:0] max_payload_q;
  logic             cfg_write;

  cls_t      cls;
  logic      cls_valid;
  logic      cls_pop;
  res_item_t res;
  logic      res_push;
  logic      res_full;
  logic [$bits(res_item_t)-1:0] res_raw;

  // Configuration registers. A write completes in the access phase.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capture_enable_q <= 1'b1;
      max_payload_q    <= MaxPayloadReset;
    end else if (cfg_write) begin
      unique case (paddr[RegSelBit])
        REG_CAPTURE: capture_enable_q <= pwdata[0];
        REG_MAX_PAY: max_payload_q    <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[RegSelBit])
      REG_CAPTURE: prdata = {63'd0, capture_enable_q};
      REG_MAX_PAY: prdata = max_payload_q;
      default:     prdata = '0;
    endcase
  end

  // Front end: classify each byte and queue it.
  oehp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_i),
    .full_o     (full_o),
    .in_item_i  (in_item_i),
    .cls_valid_o(cls_valid),
    .cls_pop_i  (cls_pop),
    .cls_o      (cls)
  );

  // Back end: parse the header, count the payload, judge the object.
  oehp_back #(
    .HEADER_MAX(HEADER_MAX)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cls_valid_i     (cls_valid),
    .cls_i           (cls),
    .cls_pop_o       (cls_pop),
    .res_full_i      (res_full),
    .res_push_o      (res_push),
    .res_o           (res),
    .capture_enable_i(capture_enable_q),
    .max_payload_i   (max_payload_q)
  );

  // Result queue: the finished result waits here while new bytes keep flowing.
  oehp_fifo #(
    .Width($bits(res_item_t))
  ) u_res_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res),
    .full_o (res_full),
    .pop_i  (pop_i),
    .empty_o(empty_o),
    .data_o (res_raw)
  );

  assign out_item_o = res_item_t'(res_raw);

endmodule

`default_nettype wire

// ===== bench/object_envelope_header_parser_tb.sv =====
// Self-checking testbench for the object envelope header parser.
`timescale 1ns / 1ps
`default_nettype none

// Objects are built as byte lists and queued for the driver. Every byte that
// the block takes runs through a behavioral copy of the parser here, and the
// result that copy predicts waits in a queue until the block hands out its
// own result for that byte. Both sides stall in random bursts if idle_on is
// set. The registers change only between phases, once every result is back.
module object_envelope_header_parser_tb;

  import oehp_pkg::*;

  localparam int HeaderMax = 128;
  localparam int HoldCycles = 40;
  localparam int StallLimit = 1000;
  localparam logic [63:0] SizeMax = '1;
  localparam logic [63:0] MaxPayloadAtReset = 64'd268435456;

  typedef enum logic [1:0] {
    PH_TYPE,
    PH_SIZE,
    PH_BODY,
    PH_STOP
  } phase_e;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  in_item_t    in_item = '0;
  logic        empty;
  logic        pop = 1'b0;
  res_item_t   out_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  object_envelope_header_parser #(
    .HEADER_MAX(HeaderMax)
  ) dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .push_i    (push),
    .full_o    (full),
    .in_item_i (in_item),
    .empty_o   (empty),
    .pop_i     (pop),
    .out_item_o(out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Parser state as seen by the predictor, plus its copy of the registers.
  string       type_names[3] = '{"blob", "tree", "commit"};
  logic        cfg_capture;
  logic [63:0] cfg_max_payload;
  phase_e      phase;
  int          hdr_len;
  logic [2:0]  type_flags;
  int          type_len;
  logic        size_seen;
  logic        size_bad;
  logic [63:0] size_acc;
  logic [63:0] payload_cnt;
  logic [3:0]  sticky_err;
  logic        hdr_ok;

  // Bytes waiting to be offered, and the results predicted for taken bytes.
  in_item_t    stream_q[$];
  res_item_t   byte_verdicts_q[$];
  logic [7:0]  obj_bytes[$];
  res_item_t   want_item;

  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          send_gap = 0;
  int          recv_gap = 0;
  int          hold_left = 0;
  bit          hold_req = 1'b0;
  bit          idle_on = 1'b1;

  function automatic void clear_object();
    phase       = PH_TYPE;
    hdr_len     = 0;
    type_flags  = '1;
    type_len    = 0;
    size_seen   = 1'b0;
    size_bad    = 1'b0;
    size_acc    = '0;
    payload_cnt = '0;
    sticky_err  = ST_RUNNING;
    hdr_ok      = 1'b0;
  endfunction

  function automatic void stop_object(input logic [3:0] code);
    sticky_err = code;
    phase      = PH_STOP;
  endfunction

  // Advances the parser copy by one byte and returns the result it yields.
  function automatic res_item_t parse_object_byte(input in_item_t it);
    res_item_t   r;
    logic [7:0]  b;
    logic [63:0] digit;
    logic [3:0]  verdict;
    b = it.in_byte;
    r = '0;
    if (phase == PH_TYPE || phase == PH_SIZE) begin
      if (b == 8'h00) begin
        // The closing NUL judges the header: shape, then type, then size text,
        // then the capture limit.
        if (phase != PH_SIZE || type_len == 0 || !size_seen) begin
          stop_object(ST_HDR_MALFORMED);
        end else begin
          for (int k = 0; k < 3; k++) begin
            if (type_len != type_names[k].len()) type_flags[k] = 1'b0;
          end
          if (type_flags == '0) begin
            stop_object(ST_BAD_TYPE);
          end else if (size_bad) begin
            stop_object(ST_BAD_SIZE);
          end else if (cfg_capture && size_acc > cfg_max_payload) begin
            stop_object(ST_TOO_LARGE);
          end else begin
            phase = PH_BODY;
            hdr_ok = 1'b1;
            r.header_done = 1'b1;
          end
        end
      end else if (hdr_len >= HeaderMax) begin
        stop_object(ST_HDR_TOO_LONG);
      end else begin
        hdr_len++;
        if (phase == PH_TYPE) begin
          if (b == CHAR_SPACE) begin
            phase = PH_SIZE;
          end else begin
            for (int k = 0; k < 3; k++) begin
              if (type_len >= type_names[k].len() || type_names[k][type_len] != b) begin
                type_flags[k] = 1'b0;
              end
            end
            if (type_len < 255) type_len++;
          end
        end else begin
          size_seen = 1'b1;
          if (!size_bad) begin
            if (b < CHAR_ZERO || b > CHAR_NINE) begin
              size_bad = 1'b1;
            end else begin
              digit = b - CHAR_ZERO;
              // Reject the digit if the value would wrap past 64 bits.
              if (size_acc > (SizeMax - digit) / 10) size_bad = 1'b1;
              else size_acc = size_acc * 10 + digit;
            end
          end
        end
      end
    end else if (phase == PH_BODY) begin
      if (payload_cnt >= size_acc) begin
        stop_object(ST_TRAILING);
      end else begin
        payload_cnt++;
        r.payload_valid = 1'b1;
        r.payload_byte  = b;
      end
    end
    if (hdr_ok) begin
      r.object_type   = type_flags[0] ? TYPE_BLOB : (type_flags[1] ? TYPE_TREE : TYPE_COMMIT);
      r.declared_size = size_acc;
    end
    verdict = sticky_err;
    if (it.end_of_object) begin
      if (sticky_err == ST_RUNNING) begin
        if (phase == PH_TYPE || phase == PH_SIZE) verdict = ST_TRUNC_HDR;
        else if (payload_cnt != size_acc) verdict = ST_TRUNC_PAYLOAD;
        else verdict = ST_OK;
      end
      clear_object();
    end
    r.status = verdict;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Driver: offers queued bytes, holding each one until the block takes it.
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        byte_verdicts_q.insert(byte_verdicts_q.size(), parse_object_byte(in_item));
      end
      if (!push || !full) begin
        if (send_gap > 0) begin
          send_gap--;
          push <= 1'b0;
        end else if (idle_on && stream_q.size() != 0 && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(0, 4);
          push <= 1'b0;
        end else if (stream_q.size() != 0) begin
          in_item <= stream_q.pop_front();
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: takes results, compares each with the oldest prediction, and
  // decides when to stall, including the one long hold that fills the block.
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (byte_verdicts_q.size() == 0) begin
          $error("result item arrived with no byte waiting for it");
          mismatches++;
        end else begin
          want_item = byte_verdicts_q.pop_front();
          check_field("payload_valid", want_item.payload_valid, out_item.payload_valid);
          check_field("payload_byte", want_item.payload_byte, out_item.payload_byte);
          check_field("header_done", want_item.header_done, out_item.header_done);
          check_field("object_type", want_item.object_type, out_item.object_type);
          check_field("declared_size", want_item.declared_size, out_item.declared_size);
          check_field("status", want_item.status, out_item.status);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HoldCycles - 1;
        pop <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        pop <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        recv_gap = $urandom_range(0, 4);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog: any handshake or register access counts as progress.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (psel && penable)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) obj_bytes.insert(obj_bytes.size(), s[i]);
  endtask

  // Moves the built bytes to the driver; the last one may close the object.
  task automatic send_object(input bit closes);
    in_item_t it;
    for (int i = 0; i < obj_bytes.size(); i++) begin
      it.in_byte = obj_bytes[i];
      it.end_of_object = closes && (i == obj_bytes.size() - 1);
      stream_q.insert(stream_q.size(), it);
    end
    obj_bytes.delete();
  endtask

  task automatic wait_all_results();
    while (stream_q.size() != 0 || push || byte_verdicts_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write over the APB port: setup cycle, then access cycle.
  task automatic reg_write(input logic sel, input logic [63:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= 4'(sel) << RegSelBit;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel == REG_CAPTURE) cfg_capture = value[0];
    else cfg_max_payload = value;
  endtask

  // Queues random objects until the byte budget is used. Most are well formed
  // with random sizes and payload; the rest probe a rule or are random bytes.
  task automatic random_objects(input int unsigned budget);
    int unsigned sent;
    int unsigned kind;
    int unsigned plen;
    int unsigned nzero;
    logic [63:0] size;
    string       tname;
    string       stext;
    bit          with_space;
    bit          with_nul;
    sent = 0;
    while (sent < budget) begin
      kind  = $urandom_range(0, 99);
      tname = type_names[$urandom_range(0, 2)];
      size  = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 40))
                                          : 64'($urandom_range(0, 8));
      stext = $sformatf("%0d", size);
      if ($urandom_range(0, 7) == 0) stext = {"0", stext};
      plen = int'(size);
      with_space = 1'b1;
      with_nul = 1'b1;
      if (kind < 58) begin
        // Well formed, payload matches the declared size.
      end else if (kind < 64) begin
        plen += $urandom_range(1, 3);
      end else if (kind < 70) begin
        plen = (size == 0) ? 0 : $urandom_range(0, plen - 1);
      end else if (kind < 75) begin
        case ($urandom_range(0, 2))
          0: tname[$urandom_range(0, tname.len() - 1)] = 8'($urandom_range(97, 122));
          1: tname = {tname, "s"};
          default: tname = tname.substr(0, tname.len() - 2);
        endcase
      end else if (kind < 79) begin
        if ($urandom_range(0, 1) == 0) stext = {stext, " 1"};
        else stext[$urandom_range(0, stext.len() - 1)] = 8'($urandom_range(1, 255));
      end else if (kind < 84) begin
        // Sizes around the 64-bit limit.
        case ($urandom_range(0, 2))
          0: stext = "18446744073709551615";
          1: stext = "18446744073709551616";
          default: stext = {$sformatf("%0d", {$urandom, $urandom}), "9"};
        endcase
        plen = $urandom_range(0, 3);
      end else if (kind < 87) begin
        with_space = 1'b0;
      end else if (kind < 89) begin
        tname = "";
      end else if (kind < 91) begin
        stext = "";
      end else if (kind < 93) begin
        // Header padded with leading zeros to land just below, at or just
        // above the length limit.
        nzero = $urandom_range(HeaderMax - 2, HeaderMax + 2) - tname.len() - 2;
        stext = "";
        repeat (nzero) stext = {stext, "0"};
        stext = {stext, "3"};
        plen = 3;
      end else if (kind < 96) begin
        with_nul = 1'b0;
      end
      if (kind >= 96) begin
        repeat ($urandom_range(1, 6)) obj_bytes.insert(obj_bytes.size(), 8'($urandom));
      end else begin
        add_text(tname);
        if (with_space) obj_bytes.insert(obj_bytes.size(), CHAR_SPACE);
        add_text(stext);
        if (with_nul) begin
          obj_bytes.insert(obj_bytes.size(), 8'h00);
          repeat (plen) obj_bytes.insert(obj_bytes.size(), 8'($urandom));
        end else begin
          // The object ends somewhere inside its header.
          repeat ($urandom_range(0, obj_bytes.size() - 1)) begin
            obj_bytes.delete(obj_bytes.size() - 1);
          end
        end
      end
      sent += obj_bytes.size();
      send_object(1'b1);
    end
  endtask

  initial begin
    clear_object();
    cfg_capture = 1'b1;
    cfg_max_payload = MaxPayloadAtReset;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed objects under the reset register values.
    obj_bytes.insert(obj_bytes.size(), 8'h00);
    send_object(1'b1);                   // NUL with no type at all
    obj_bytes.insert(obj_bytes.size(), 8'hFF);
    send_object(1'b1);                   // object ends inside the type
    add_text("tree 1");
    obj_bytes.insert(obj_bytes.size(), 8'h00);
    obj_bytes.insert(obj_bytes.size(), 8'hFF);
    send_object(1'b1);                   // clean tree, top byte value
    add_text("commit 2");
    obj_bytes.insert(obj_bytes.size(), 8'h00);
    obj_bytes.insert(obj_bytes.size(), 8'h00);
    send_object(1'b0);
    // The sender stops mid-object until everything has drained.
    wait_all_results();
    obj_bytes.insert(obj_bytes.size(), 8'h41);
    obj_bytes.insert(obj_bytes.size(), 8'h42);
    send_object(1'b1);                   // one byte past the declared size
    add_text("blob 5");
    obj_bytes.insert(obj_bytes.size(), 8'h00);
    obj_bytes.insert(obj_bytes.size(), 8'h01);
    send_object(1'b1);                   // payload cut short
    add_text("blob 0");
    obj_bytes.insert(obj_bytes.size(), 8'h00);
    send_object(1'b1);                   // empty payload ends on the NUL
    random_objects(50);
    wait_all_results();

    // Limit at zero: only empty payloads pass. The long receiver hold sits
    // here so that the block fills and pushes back on the sender.
    reg_write(REG_CAPTURE, {32'($urandom), 31'($urandom), 1'b1});
    reg_write(REG_MAX_PAY, '0);
    random_objects(50);
    hold_req = 1'b1;
    wait_all_results();

    // No limit, and a stretch with no idling on either side.
    idle_on = 1'b0;
    reg_write(REG_CAPTURE, {32'($urandom), 31'($urandom), 1'b0});
    reg_write(REG_MAX_PAY, {$urandom, $urandom});
    random_objects(50);
    wait_all_results();

    idle_on = 1'b1;
    reg_write(REG_CAPTURE, 64'd1);
    reg_write(REG_MAX_PAY, SizeMax);
    random_objects(60);
    wait_all_results();

    reg_write(REG_MAX_PAY, 64'($urandom_range(0, 20)));
    random_objects(60);
    wait_all_results();

    // Closing part runs at full rate.
    idle_on = 1'b0;
    reg_write(REG_CAPTURE, 64'd0);
    reg_write(REG_MAX_PAY, {$urandom, $urandom});
    random_objects(60);
    wait_all_results();

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== object_envelope_header_parser.f =====
sv/oehp_pkg.sv
sv/oehp_fifo.sv
sv/oehp_front.sv
sv/oehp_back.sv
sv/object_envelope_header_parser.sv
bench/object_envelope_header_parser_tb.sv
